// ----- hw/rtl/ffra_pkg.sv -----
`default_nettype none
package ffra_pkg;

  // fixed field widths
  localparam int IDX_W = 16;
  localparam int ST_W  = 3;

  // default table sizes
  localparam int GAP_SLOTS_DEF  = 16;
  localparam int LIVE_SLOTS_DEF = 64;

  // command codes
  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_PURGE = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;  // unused code, no effect

  // status codes
  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_NOSPACE  = 3'd1;
  localparam logic [ST_W-1:0] ST_UNKNOWN  = 3'd2;
  localparam logic [ST_W-1:0] ST_GAPFULL  = 3'd3;
  localparam logic [ST_W-1:0] ST_LIVEFULL = 3'd4;

  // register map
  localparam int         PADDR_W       = 3;
  localparam int         PDATA_W       = 32;
  localparam logic       REG_MAX_INDEX = 1'b0;
  localparam logic [IDX_W-1:0] MAX_INDEX_RST = 16'hFFFF;

  typedef struct packed {
    logic [1:0]       command;
    logic [IDX_W-1:0] count;
    logic [IDX_W-1:0] handle;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0] start_index;
    logic [ST_W-1:0]  status;
    logic [IDX_W-1:0] next_index;
  } rsp_t;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_CLEAR,
    OP_LOAD,
    OP_LSCAN,
    OP_GINIT,
    OP_GSCAN,
    OP_DECIDE,
    OP_SD,
    OP_SU,
    OP_EMIT
  } op_t;

  // datapath status back to the controller
  typedef struct packed {
    logic clr_last;
    logic lscan_done;
    logic lhit;
    logic gscan_done;
    logic rm;
    logic ins;
    logic sd_done;
    logic su_done;
    logic out_room;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- hw/rtl/ffra_ctrl.sv -----
`default_nettype none
module ffra_ctrl
  import ffra_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic [1:0] in_cmd,
  output logic          in_stall,
  input  wire dp_stat_t stat,
  output op_t           op
);

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_LSCAN,
    S_GINIT,
    S_GSCAN,
    S_DECIDE,
    S_SD,
    S_SU,
    S_DONE
  } state_t;

  state_t     state_r, state_nxt;
  logic       in_stall_r;
  logic [1:0] cmd_r;

  // next state and operation
  always_comb begin
    state_nxt = state_r;
    op        = OP_IDLE;
    unique case (state_r)
      S_CLR: begin
        op = OP_CLEAR;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          op = OP_LOAD;
          if (in_cmd == CMD_ALLOC || in_cmd == CMD_FREE || in_cmd == CMD_PURGE) begin
            state_nxt = S_LSCAN;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_LSCAN: begin
        op = OP_LSCAN;
        if (stat.lscan_done) begin
          state_nxt = (cmd_r != CMD_PURGE && !stat.lhit) ? S_DECIDE : S_GINIT;
        end
      end
      S_GINIT: begin
        op        = OP_GINIT;
        state_nxt = S_GSCAN;
      end
      S_GSCAN: begin
        op = OP_GSCAN;
        if (stat.gscan_done) state_nxt = (cmd_r == CMD_PURGE) ? S_DONE : S_DECIDE;
      end
      S_DECIDE: begin
        op = OP_DECIDE;
        if (stat.rm) begin
          state_nxt = S_SD;
        end else if (stat.ins) begin
          state_nxt = S_SU;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SD: begin
        op = OP_SD;
        if (stat.sd_done) state_nxt = S_DONE;
      end
      S_SU: begin
        op = OP_SU;
        if (stat.su_done) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_room) begin
          op        = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      in_stall_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= (state_nxt != S_IDLE);
    end
    if (state_r == S_IDLE && in_valid) cmd_r <= in_cmd;
  end

  assign in_stall = in_stall_r;

endmodule
`default_nettype wire

// ----- hw/rtl/ffra_dpath.sv -----
`default_nettype none
module ffra_dpath
  import ffra_pkg::*;
#(
  parameter int GAP_SLOTS  = GAP_SLOTS_DEF,
  parameter int LIVE_SLOTS = LIVE_SLOTS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire op_t              op,
  input  wire req_t             in_data,
  input  wire logic [IDX_W-1:0] max_index,
  input  wire logic             out_stall,
  output logic                  out_valid,
  output rsp_t                  out_data,
  output dp_stat_t              stat
);

  localparam int W   = IDX_W;
  localparam int GIW = $clog2(GAP_SLOTS);
  localparam int GCW = $clog2(GAP_SLOTS + 1);
  localparam int LIW = $clog2(LIVE_SLOTS);
  localparam int LW  = 1 + 2 * W;
  localparam int GW  = 2 * W;
  localparam logic [LIW:0]   L_END  = (LIW + 1)'(LIVE_SLOTS);
  localparam logic [LIW:0]   L_LAST = (LIW + 1)'(LIVE_SLOTS - 1);
  localparam logic [LIW-1:0] L_LIDX = LIW'(LIVE_SLOTS - 1);
  localparam logic [GCW-1:0] G_FULL = GCW'(GAP_SLOTS);
  localparam logic [GCW-1:0] G_ONE  = GCW'(1);

  // memories
  logic [LW-1:0] live_mem [LIVE_SLOTS];
  logic [GW-1:0] gap_mem  [GAP_SLOTS];
  logic [LW-1:0] live_q;
  logic [GW-1:0] gap_q;

  logic           live_we, gap_we;
  logic [LIW-1:0] live_wa, live_ra;
  logic [LW-1:0]  live_wd;
  logic [GIW-1:0] gap_wa, gap_ra;
  logic [GW-1:0]  gap_wd;

  // control registers
  logic [LIW:0]   lptr_r, lptr_nxt;
  logic           lpend_r, lpend_nxt;
  logic [GCW-1:0] gptr_r, gptr_nxt;
  logic           gpend_r, gpend_nxt;
  logic [GCW-1:0] gcnt_r, gcnt_nxt;
  logic [W-1:0]   bump_r, bump_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           found_r, found_nxt;
  logic           cur_ok_r, cur_ok_nxt;

  // payload registers
  logic [1:0]     cmd_r, cmd_nxt;
  logic [W-1:0]   count_r, count_nxt;
  logic [W-1:0]   handle_r, handle_nxt;
  logic [LIW-1:0] lpidx_r, lpidx_nxt;
  logic [GCW-1:0] gpidx_r, gpidx_nxt;
  logic [LIW-1:0] slot_r, slot_nxt;
  logic [W-1:0]   n_r, n_nxt;
  logic [W:0]     top_r, top_nxt;
  logic [GCW-1:0] pos_r, pos_nxt;
  logic [GCW-1:0] k_r, k_nxt;
  logic [W-1:0]   prev_start_r, prev_start_nxt;
  logic [W-1:0]   prev_size_r, prev_size_nxt;
  logic [W:0]     prev_end_r, prev_end_nxt;
  logic [W-1:0]   cur_start_r, cur_start_nxt;
  logic [W-1:0]   cur_size_r, cur_size_nxt;
  logic [W-1:0]   granted_r, granted_nxt;
  logic [ST_W-1:0] status_r, status_nxt;
  rsp_t           out_data_r, out_data_nxt;

  // decoded read data and helpers
  logic           lv;
  logic [W-1:0]   ls, lsz, gs, gsz, topm, ns;
  logic [W:0]     live_end, gap_end, bump_sum, merge_end, right_end;
  logic           is_alloc, is_free, is_purge;
  logic           lhit, lend, ghit, gend, keep;
  logic           left_touch, bridge, right_touch;
  logic           rm, ins, sd_done, su_done;
  logic [ST_W-1:0] dec_st;
  logic [GCW-1:0] pos_m1, sd_wa, su_wa, su_ra;

  assign lv  = live_q[LW-1];
  assign ls  = live_q[2*W-1:W];
  assign lsz = live_q[W-1:0];
  assign gs  = gap_q[GW-1:W];
  assign gsz = gap_q[W-1:0];
  assign topm = top_r[W-1:0];

  assign is_alloc = (cmd_r == CMD_ALLOC);
  assign is_free  = (cmd_r == CMD_FREE);
  assign is_purge = (cmd_r == CMD_PURGE);

  assign live_end = {1'b0, ls} + {1'b0, lsz};
  assign gap_end  = {1'b0, gs} + {1'b0, gsz};
  assign bump_sum = {1'b0, bump_r} + {1'b0, count_r};

  // scan hit tests
  assign lhit = lpend_r && (is_alloc ? !lv : (is_free ? (lv && ls == handle_r) : 1'b0));
  assign lend = lpend_r && !lhit && (lpidx_r == L_LIDX);
  assign ghit = gpend_r && (is_alloc ? (count_r <= gsz) : (is_free ? (gs >= handle_r) : 1'b0));
  assign gend = (gcnt_r == '0) || (gpend_r && !ghit && (gpidx_r + G_ONE == gcnt_r));
  assign keep = (gs < topm);

  // merge tests for free
  assign ns          = prev_size_r + n_r;
  assign merge_end   = {1'b0, prev_start_r} + {1'b0, ns};
  assign right_end   = {1'b0, handle_r} + {1'b0, n_r};
  assign left_touch  = (pos_r != '0) && (prev_end_r == {1'b0, handle_r});
  assign bridge      = cur_ok_r && (merge_end == {1'b0, cur_start_r});
  assign right_touch = cur_ok_r && ({1'b0, cur_start_r} == right_end);

  assign pos_m1 = pos_r - G_ONE;
  assign sd_wa  = gpidx_r - G_ONE;
  assign su_wa  = gpidx_r + G_ONE;
  assign su_ra  = gptr_r - G_ONE;
  assign sd_done = (gptr_r >= gcnt_r);
  assign su_done = (gptr_r == pos_r) && !gpend_r;

  always_comb begin
    lptr_nxt = lptr_r;   lpend_nxt = lpend_r;
    gptr_nxt = gptr_r;   gpend_nxt = gpend_r;
    gcnt_nxt = gcnt_r;   bump_nxt = bump_r;
    found_nxt = found_r; cur_ok_nxt = cur_ok_r;
    cmd_nxt = cmd_r;     count_nxt = count_r;   handle_nxt = handle_r;
    lpidx_nxt = lpidx_r; gpidx_nxt = gpidx_r;
    slot_nxt = slot_r;   n_nxt = n_r;           top_nxt = top_r;
    pos_nxt = pos_r;     k_nxt = k_r;
    prev_start_nxt = prev_start_r; prev_size_nxt = prev_size_r;
    prev_end_nxt = prev_end_r;
    cur_start_nxt = cur_start_r;   cur_size_nxt = cur_size_r;
    granted_nxt = granted_r;       status_nxt = status_r;
    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    live_we = 1'b0; live_wa = lptr_r[LIW-1:0]; live_wd = '0; live_ra = lptr_r[LIW-1:0];
    gap_we = 1'b0;  gap_wa = '0; gap_wd = '0; gap_ra = gptr_r[GIW-1:0];
    rm = 1'b0; ins = 1'b0; dec_st = ST_OK;

    unique case (op)
      // sweep the live table clear after reset
      OP_CLEAR: begin
        live_we  = 1'b1;
        lptr_nxt = lptr_r + 1'b1;
      end
      OP_LOAD: begin
        cmd_nxt     = in_data.command;
        count_nxt   = in_data.count;
        handle_nxt  = in_data.handle;
        lptr_nxt    = '0;
        lpend_nxt   = 1'b0;
        top_nxt     = '0;
        found_nxt   = 1'b0;
        granted_nxt = '0;
        status_nxt  = ST_OK;
      end
      // live table walk, one entry a cycle
      OP_LSCAN: begin
        lpend_nxt = 1'b0;
        if (lptr_r < L_END) begin
          lptr_nxt  = lptr_r + 1'b1;
          lpidx_nxt = lptr_r[LIW-1:0];
          lpend_nxt = 1'b1;
        end
        if (lhit) begin
          found_nxt = 1'b1;
          slot_nxt  = lpidx_r;
          n_nxt     = lsz;
        end
        if (lpend_r && is_purge && lv && live_end > top_r) top_nxt = live_end;
      end
      OP_GINIT: begin
        gptr_nxt   = '0;
        gpend_nxt  = 1'b0;
        k_nxt      = '0;
        cur_ok_nxt = 1'b0;
        if (is_purge) bump_nxt = topm;
      end
      // gap list walk; purge compacts in place
      OP_GSCAN: begin
        gpend_nxt = 1'b0;
        if (gptr_r < gcnt_r) begin
          gptr_nxt  = gptr_r + G_ONE;
          gpidx_nxt = gptr_r;
          gpend_nxt = 1'b1;
        end
        if (gpend_r) begin
          if (is_purge) begin
            if (keep) begin
              gap_we = 1'b1;
              gap_wa = k_r[GIW-1:0];
              gap_wd = {gs, (gap_end >= {1'b0, topm}) ? topm - gs : gsz};
              k_nxt  = k_r + G_ONE;
            end
          end else if (ghit) begin
            pos_nxt       = gpidx_r;
            cur_start_nxt = gs;
            cur_size_nxt  = gsz;
            cur_ok_nxt    = 1'b1;
          end else begin
            prev_start_nxt = gs;
            prev_size_nxt  = gsz;
            prev_end_nxt   = gap_end;
          end
        end
        if (gend) begin
          pos_nxt    = gcnt_r;
          cur_ok_nxt = 1'b0;
          if (is_purge) gcnt_nxt = k_nxt;
        end
      end
      // final outcome of allocate or free
      OP_DECIDE: begin
        if (is_alloc) begin
          if (!found_r) begin
            dec_st = ST_LIVEFULL;
          end else if (count_r == '0) begin
            dec_st = ST_NOSPACE;
          end else if (cur_ok_r) begin
            granted_nxt = cur_start_r;
            live_we = 1'b1;
            live_wa = slot_r;
            live_wd = {1'b1, cur_start_r, count_r};
            if (count_r < cur_size_r) begin
              gap_we = 1'b1;
              gap_wa = pos_r[GIW-1:0];
              gap_wd = {cur_start_r + count_r, cur_size_r - count_r};
            end else begin
              rm = 1'b1;
            end
          end else if (bump_sum >= {1'b0, max_index}) begin
            dec_st = ST_NOSPACE;
          end else begin
            granted_nxt = bump_r;
            bump_nxt    = bump_sum[W-1:0];
            live_we = 1'b1;
            live_wa = slot_r;
            live_wd = {1'b1, bump_r, count_r};
          end
        end else if (is_free) begin
          if (!found_r) begin
            dec_st = ST_UNKNOWN;
          end else if (left_touch) begin
            live_we = 1'b1;
            live_wa = slot_r;
            gap_we  = 1'b1;
            gap_wa  = pos_m1[GIW-1:0];
            if (bridge) begin
              gap_wd = {prev_start_r, ns + cur_size_r};
              rm     = 1'b1;
            end else begin
              gap_wd = {prev_start_r, ns};
            end
          end else if (right_touch) begin
            live_we = 1'b1;
            live_wa = slot_r;
            gap_we  = 1'b1;
            gap_wa  = pos_r[GIW-1:0];
            gap_wd  = {handle_r, cur_size_r + n_r};
          end else if (gcnt_r >= G_FULL) begin
            dec_st = ST_GAPFULL;
          end else begin
            live_we = 1'b1;
            live_wa = slot_r;
            ins     = 1'b1;
          end
        end
        status_nxt = dec_st;
        if (rm) begin
          gptr_nxt  = pos_r + G_ONE;
          gpend_nxt = 1'b0;
        end
        if (ins) begin
          gptr_nxt  = gcnt_r;
          gpend_nxt = 1'b0;
        end
      end
      // close the hole at pos, moving later gaps down
      OP_SD: begin
        gpend_nxt = 1'b0;
        if (gpend_r) begin
          gap_we = 1'b1;
          gap_wa = sd_wa[GIW-1:0];
          gap_wd = gap_q;
        end
        if (!sd_done) begin
          gptr_nxt  = gptr_r + G_ONE;
          gpidx_nxt = gptr_r;
          gpend_nxt = 1'b1;
        end else begin
          gcnt_nxt = gcnt_r - G_ONE;
        end
      end
      // open a hole at pos, moving later gaps up, then fill it
      OP_SU: begin
        gap_ra    = su_ra[GIW-1:0];
        gpend_nxt = 1'b0;
        if (gpend_r) begin
          gap_we = 1'b1;
          gap_wa = su_wa[GIW-1:0];
          gap_wd = gap_q;
        end
        if (gptr_r > pos_r) begin
          gptr_nxt  = su_ra;
          gpidx_nxt = su_ra;
          gpend_nxt = 1'b1;
        end else if (su_done) begin
          gap_we   = 1'b1;
          gap_wa   = pos_r[GIW-1:0];
          gap_wd   = {handle_r, n_r};
          gcnt_nxt = gcnt_r + G_ONE;
        end
      end
      OP_EMIT: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{start_index: granted_r, status: status_r, next_index: bump_r};
      end
      default: ;
    endcase
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (live_we) live_mem[live_wa] <= live_wd;
    live_q <= live_mem[live_ra];
  end

  always_ff @(posedge clk) begin
    if (gap_we) gap_mem[gap_wa] <= gap_wd;
    gap_q <= gap_mem[gap_ra];
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lptr_r      <= '0;
      lpend_r     <= 1'b0;
      gptr_r      <= '0;
      gpend_r     <= 1'b0;
      gcnt_r      <= '0;
      bump_r      <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      cur_ok_r    <= 1'b0;
    end else begin
      lptr_r      <= lptr_nxt;
      lpend_r     <= lpend_nxt;
      gptr_r      <= gptr_nxt;
      gpend_r     <= gpend_nxt;
      gcnt_r      <= gcnt_nxt;
      bump_r      <= bump_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
      cur_ok_r    <= cur_ok_nxt;
    end
    cmd_r        <= cmd_nxt;
    count_r      <= count_nxt;
    handle_r     <= handle_nxt;
    lpidx_r      <= lpidx_nxt;
    gpidx_r      <= gpidx_nxt;
    slot_r       <= slot_nxt;
    n_r          <= n_nxt;
    top_r        <= top_nxt;
    pos_r        <= pos_nxt;
    k_r          <= k_nxt;
    prev_start_r <= prev_start_nxt;
    prev_size_r  <= prev_size_nxt;
    prev_end_r   <= prev_end_nxt;
    cur_start_r  <= cur_start_nxt;
    cur_size_r   <= cur_size_nxt;
    granted_r    <= granted_nxt;
    status_r     <= status_nxt;
    out_data_r   <= out_data_nxt;
  end

  always_comb begin
    stat.clr_last   = (lptr_r == L_LAST);
    stat.lscan_done = lhit || lend;
    stat.lhit       = lhit;
    stat.gscan_done = ghit || gend;
    stat.rm         = rm;
    stat.ins        = ins;
    stat.sd_done    = sd_done;
    stat.su_done    = su_done;
    stat.out_room   = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_gcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    gcnt_r <= G_FULL) else $error("gap count beyond capacity");

  a_rm_ins_excl: assert property (@(posedge clk) disable iff (!rst_n)
    op == OP_DECIDE |-> !(rm && ins)) else $error("remove and insert together");

  a_su_room: assert property (@(posedge clk) disable iff (!rst_n)
    op == OP_SU |-> gcnt_r < G_FULL) else $error("insert into full gap list");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    op == OP_EMIT |=> out_valid_r) else $error("result lost on emit");

  a_err_stable: assert property (@(posedge clk) disable iff (!rst_n)
    op == OP_DECIDE && dec_st != ST_OK |=> $stable(gcnt_r) && $stable(bump_r))
    else $error("failed request changed state");

endmodule
`default_nettype wire

// ----- hw/rtl/first_fit_range_allocator_core.sv -----
// Allocate and free walk the live table and, when it holds a match, the gap list,
//   then may shift later gaps down or up. Purge walks both and compacts the gap list;
//   other commands walk neither.
// Throughput: one request at a time; the next is taken once the previous is finished.
// Reset (synchronous, rst_n low) clears the counters, then a pass over every live
//   slot clears the live table while in_stall stays high.
`default_nettype none
module first_fit_range_allocator_core
  import ffra_pkg::*;
#(
  parameter int GAP_SLOTS  = GAP_SLOTS_DEF,
  parameter int LIVE_SLOTS = LIVE_SLOTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire req_t               in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output rsp_t                    out_data,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready
);

  logic [IDX_W-1:0] max_index_r;
  op_t              op;
  dp_stat_t         stat;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_index_r <= MAX_INDEX_RST;
    end else if (psel && penable && pwrite && paddr[2] == REG_MAX_INDEX) begin
      max_index_r <= pwdata[IDX_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_INDEX) ?
                  {{(PDATA_W - IDX_W){1'b0}}, max_index_r} : '0;

  ffra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_data.command),
    .in_stall (in_stall),
    .stat     (stat),
    .op       (op)
  );

  ffra_dpath #(
    .GAP_SLOTS  (GAP_SLOTS),
    .LIVE_SLOTS (LIVE_SLOTS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .in_data   (in_data),
    .max_index (max_index_r),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .stat      (stat)
  );

endmodule
`default_nettype wire

// ----- bench/alloc_checker.sv -----
`default_nettype none
module alloc_checker
  import ffra_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_valid,
  input  wire logic   in_stall,
  input  wire req_t   in_data,
  input  wire logic   out_valid,
  input  wire logic   out_stall,
  input  wire rsp_t   out_data,
  input  wire logic   cfg_wr,
  input  wire logic [IDX_W-1:0] cfg_max,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GAPS = GAP_SLOTS_DEF;
  localparam int LIVES = LIVE_SLOTS_DEF;

  // allocator state as predicted
  logic [IDX_W-1:0] gs [GAPS];
  logic [IDX_W-1:0] gz [GAPS];
  int               gn;
  logic [IDX_W-1:0] ls [LIVES];
  logic [IDX_W-1:0] lz [LIVES];
  bit               lv [LIVES];
  logic [IDX_W-1:0] bump;
  logic [IDX_W-1:0] limit;

  rsp_t expected_rsps [$];

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  function automatic void gap_drop(input int at);
    for (int i = at; i + 1 < gn; i++) begin
      gs[i] = gs[i+1];
      gz[i] = gz[i+1];
    end
    gn--;
  endfunction

  function automatic logic [ST_W-1:0] grant(input logic [IDX_W-1:0] n,
                                            output logic [IDX_W-1:0] s);
    int slot;
    int i;
    slot = -1;
    s = '0;
    for (i = 0; i < LIVES; i++) if (!lv[i]) begin slot = i; break; end
    if (slot < 0) return ST_LIVEFULL;
    if (n == 0) return ST_NOSPACE;
    for (i = 0; i < gn; i++) if (n <= gz[i]) break;
    if (i < gn) begin
      s = gs[i];
      if (n < gz[i]) begin
        gs[i] = gs[i] + n;
        gz[i] = gz[i] - n;
      end else gap_drop(i);
    end else begin
      if (32'(bump) + 32'(n) >= 32'(limit)) return ST_NOSPACE;
      s = bump;
      bump = bump + n;
    end
    ls[slot] = s;
    lz[slot] = n;
    lv[slot] = 1;
    return ST_OK;
  endfunction

  function automatic logic [ST_W-1:0] release_range(input logic [IDX_W-1:0] h);
    int slot;
    int p;
    logic [IDX_W-1:0] n;
    slot = -1;
    for (int i = 0; i < LIVES; i++)
      if (lv[i] && ls[i] == h) begin slot = i; break; end
    if (slot < 0) return ST_UNKNOWN;
    n = lz[slot];
    for (p = 0; p < gn; p++) if (gs[p] >= h) break;
    if (p > 0 && 32'(gs[p-1]) + 32'(gz[p-1]) == 32'(h)) begin
      gz[p-1] = gz[p-1] + n;
      if (p < gn && 32'(gs[p-1]) + 32'(gz[p-1]) == 32'(gs[p])) begin
        gz[p-1] = gz[p-1] + gz[p];
        gap_drop(p);
      end
    end else if (p < gn && 32'(gs[p]) == 32'(h) + 32'(n)) begin
      gs[p] = h;
      gz[p] = gz[p] + n;
    end else begin
      if (gn >= GAPS) return ST_GAPFULL;
      for (int i = gn; i > p; i--) begin
        gs[i] = gs[i-1];
        gz[i] = gz[i-1];
      end
      gs[p] = h;
      gz[p] = n;
      gn++;
    end
    lv[slot] = 0;
    return ST_OK;
  endfunction

  function automatic void purge_top();
    logic [31:0] top;
    int k;
    top = 0;
    k = 0;
    for (int i = 0; i < LIVES; i++)
      if (lv[i] && 32'(ls[i]) + 32'(lz[i]) > top) top = 32'(ls[i]) + 32'(lz[i]);
    top = top & 32'hFFFF;
    bump = top[IDX_W-1:0];
    for (int i = 0; i < gn; i++) begin
      if (32'(gs[i]) >= top) continue;
      gz[k] = (32'(gs[i]) + 32'(gz[i]) >= top) ? IDX_W'(top - 32'(gs[i])) : gz[i];
      gs[k] = gs[i];
      k++;
    end
    gn = k;
  endfunction

  function automatic rsp_t predict(input req_t r);
    rsp_t o;
    logic [IDX_W-1:0] s;
    o = '0;
    s = '0;
    case (r.command)
      CMD_ALLOC: begin
        o.status = grant(r.count, s);
        if (o.status == ST_OK) o.start_index = s;
      end
      CMD_FREE:  o.status = release_range(r.handle);
      CMD_PURGE: purge_top();
      default:   o.status = ST_OK;
    endcase
    o.next_index = bump;
    return o;
  endfunction

  // predict on each accepted request, compare each accepted result
  always @(posedge clk) begin
    rsp_t want;
    if (!rst_n) begin
      gn = 0;
      bump = '0;
      limit = MAX_INDEX_RST;
      for (int i = 0; i < LIVES; i++) lv[i] = 0;
      expected_rsps.delete();
      fail_count = 0;
    end else begin
      if (cfg_wr) limit = cfg_max;
      if (in_valid && !in_stall) expected_rsps.push_back(predict(in_data));
      if (out_valid && !out_stall) begin
        if (expected_rsps.size() == 0) report("unexpected result", 0, 0);
        else begin
          want = expected_rsps.pop_front();
          if (out_data.start_index !== want.start_index)
            report("start_index", out_data.start_index, want.start_index);
          if (out_data.status !== want.status)
            report("status", out_data.status, want.status);
          if (out_data.next_index !== want.next_index)
            report("next_index", out_data.next_index, want.next_index);
        end
      end
    end
    pending = expected_rsps.size();
  end
endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
`default_nettype none
module testbench;
  import ffra_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  req_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  rsp_t out_data;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [PADDR_W-1:0] cfg_paddr = '0;
  logic [PDATA_W-1:0] cfg_pwdata = '0;
  logic [PDATA_W-1:0] cfg_prdata;
  logic cfg_pready;
  int fail_count, pending;
  int send_idle = 0, recv_stall = 0;
  bit hold_off = 0;
  int idle_cycles = 0;

  always #2 clk = ~clk;

  first_fit_range_allocator_core u_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .psel(cfg_psel), .penable(cfg_penable), .pwrite(cfg_pwrite), .paddr(cfg_paddr),
    .pwdata(cfg_pwdata), .prdata(cfg_prdata), .pready(cfg_pready)
  );

  alloc_checker u_chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_wr(cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
            && cfg_paddr == PADDR_W'(4 * REG_MAX_INDEX)),
    .cfg_max(cfg_pwdata[IDX_W-1:0]), .fail_count, .pending
  );

  // receiver stall, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_off) out_stall <= 1;
    else out_stall <= ($urandom_range(99) < recv_stall);
  end

  // watchdog on accepted requests and results
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_max(input logic [IDX_W-1:0] v);
    @(posedge clk);
    cfg_psel <= 1; cfg_pwrite <= 1;
    cfg_paddr <= PADDR_W'(4 * REG_MAX_INDEX); cfg_pwdata <= 32'(v);
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
  endtask

  // drop the request line and wait for every result
  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // one request: random gap, then hold until accepted
  task automatic send(input logic [1:0] c, input logic [IDX_W-1:0] n,
                      input logic [IDX_W-1:0] h);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= '{command: c, count: n, handle: h};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [IDX_W-1:0] pick_count();
    case ($urandom_range(9))
      0: return IDX_W'($urandom);
      1: return 0;
      default: return IDX_W'($urandom_range(1, 40));
    endcase
  endfunction

  // handle at or below the next index of the last result, sometimes at random
  function automatic logic [IDX_W-1:0] pick_handle();
    if ($urandom_range(9) == 0 || out_data.next_index == 0) return IDX_W'($urandom);
    return IDX_W'($urandom_range(0, out_data.next_index));
  endfunction

  task automatic random_phase(input int items, input int si, input int rs);
    int r;
    send_idle = si;
    recv_stall = rs;
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(99);
      if (r < 50) send(CMD_ALLOC, pick_count(), 0);
      else if (r < 90) send(CMD_FREE, 0, pick_handle());
      else if (r < 97) send(CMD_PURGE, IDX_W'($urandom), IDX_W'($urandom));
      else send(CMD_NOP, IDX_W'($urandom), IDX_W'($urandom));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1;
    drain();
    // directed: extremes, every command, special cases
    send(CMD_ALLOC, 0, 16'hFFFF);
    send(CMD_ALLOC, 16'hFFFF, 0);
    send(CMD_ALLOC, 16'hFFFE, 0);
    send(CMD_PURGE, 0, 0);
    send(CMD_NOP, 16'hFFFF, 16'hFFFF);
    send(CMD_ALLOC, 10, 0);
    send(CMD_ALLOC, 20, 0);
    send(CMD_ALLOC, 30, 0);
    send(CMD_FREE, 0, 10);
    send(CMD_ALLOC, 20, 0);
    send(CMD_FREE, 0, 12345);
    send(CMD_FREE, 0, 0);
    send(CMD_FREE, 0, 30);
    send(CMD_ALLOC, 5, 0);
    send(CMD_PURGE, 0, 0);
    send(CMD_FREE, 0, 5);
    send(CMD_FREE, 0, 60);
    send(CMD_PURGE, 0, 0);
    for (int i = 0; i < 68; i++) send(CMD_ALLOC, 1, 0);
    for (int i = 0; i < 40; i += 2) send(CMD_FREE, 0, IDX_W'(i));
    drain();
    // small limit with several settings
    write_max(16'd0);
    send(CMD_ALLOC, 1, 0);
    drain();
    write_max(16'd300);
    random_phase(300, 0, 0);
    drain();
    write_max(16'd120);
    random_phase(300, 51, 0);
    // long receiver hold-off while requests keep coming
    fork
      begin hold_off = 1; repeat (400) @(posedge clk); hold_off = 0; end
      random_phase(20, 0, 0);
    join
    drain();
    write_max(16'hFFFF);
    random_phase(300, 0, 51);
    drain();
    write_max(16'd1000);
    random_phase(300, 23, 23);
    drain();
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire
